[rtl/core/spfs_pkg.sv]
// package for the sorted packed fingerprint store
// holds field structs, operation codes, default sizes and the cell control struct
// no dependencies
package spfs_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 32;
   localparam int FP_BITS_DEFAULT     = 8;

   localparam int FUNC_W     = 2;
   localparam int IDX_FIELD_W = 6;
   localparam int FP_FIELD_W  = 8;

   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]      func;
      logic [IDX_FIELD_W-1:0] run_start;
      logic [IDX_FIELD_W-1:0] run_end;
      logic [FP_FIELD_W-1:0]  fingerprint;
   } req_type;

   typedef struct packed {
      logic                   found;
      logic [IDX_FIELD_W-1:0] slot;
      logic [IDX_FIELD_W-1:0] occupancy;
   } rsp_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic capture;     // latch compare flags for a new transfer
      logic shift_up;    // insert: open a gap at the slot
      logic shift_down;  // found remove: close the gap at the slot
   } cell_ctrl_type;

endpackage

[rtl/core/spfs_cell.sv]
// one storage cell of the fingerprint chain
// holds one entry, its compare flags, and passes the slot marker to the next cell
// depends on spfs_pkg
module spfs_cell #(
   parameter int CELL_IDX = 0,
   parameter int FP_BITS  = spfs_pkg::FP_BITS_DEFAULT,
   parameter int CNT_W    = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  spfs_pkg::cell_ctrl_type ctrl,
   input  logic [FP_BITS-1:0]     fp,
   input  logic [CNT_W-1:0]       run_lo,
   input  logic [CNT_W-1:0]       run_hi,
   input  logic [CNT_W-1:0]       base,
   input  logic                   prior_in,
   output logic                   prior_out,
   input  logic [FP_BITS-1:0]     lower_entry,
   input  logic [FP_BITS-1:0]     upper_entry,
   output logic [FP_BITS-1:0]     entry,
   output logic                   at_slot,
   output logic                   found
);
   import spfs_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

   logic [FP_BITS-1:0] entry_ff, entry_in;
   logic               mark_ff, mark_in;
   logic               eq_ff, eq_in;
   logic               in_run;

   assign in_run  = (MY_IDX >= run_lo) && (MY_IDX < run_hi);
   assign mark_in = (in_run && (fp <= entry_ff)) || (MY_IDX == base);
   assign eq_in   = in_run && (fp == entry_ff);

   assign at_slot   = mark_ff & ~prior_in;
   assign prior_out = prior_in | mark_ff;
   assign found     = at_slot & eq_ff;
   assign entry     = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift_up) begin
         if (at_slot) begin
            entry_in = fp;
         end else if (prior_in) begin
            entry_in = lower_entry;
         end
      end else if (ctrl.shift_down) begin
         if (at_slot || prior_in) begin
            entry_in = upper_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         mark_ff  <= 1'b0;
         eq_ff    <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         if (ctrl.capture) begin
            mark_ff <= mark_in;
            eq_ff   <= eq_in;
         end
      end
   end

endmodule

[rtl/core/sorted_packed_fingerprint_store_unit.sv]
// top level of the sorted packed fingerprint store
// a row of spfs_cell instances plus the sequencer, count and result register
// depends on spfs_pkg and spfs_cell
//
// A transfer runs in a compare cycle and an update cycle: the first latches, in every cell
// at once, whether its entry lies in the run and is at least the fingerprint;
// the update cycle ripples the slot marker along the cell chain, shifts the
// entries for an insert or a found remove, and loads the result register. busy
// is high only in that update cycle, so no new transfer is taken while busy,
// but one can be taken while the previous result is on the rsp_ ports. The result
// is presented for exactly one cycle with rsp_valid high, in the cycle right
// after the busy cycle, starting at the edge where busy drops; the receiver
// cannot stall it and must take it then. The split into compare and update
// cycles is set by the registered compare flags in the cells and the marker
// chain through all MAX_ENTRIES cells in the update cycle.
module sorted_packed_fingerprint_store_unit #(
   parameter int MAX_ENTRIES = spfs_pkg::MAX_ENTRIES_DEFAULT,
   parameter int FP_BITS     = spfs_pkg::FP_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  spfs_pkg::req_type req,
   output logic              rsp_valid,
   output spfs_pkg::rsp_type rsp
);
   import spfs_pkg::*;

   // wide enough to hold MAX_ENTRIES itself
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [CNT_W-1:0] MAX_IDX = CNT_W'(MAX_ENTRIES);

   // sequencer and transfer state
   logic               busy_ff, busy_in;
   logic [FUNC_W-1:0]  func_ff;
   logic [FP_BITS-1:0] fp_ff;
   logic [CNT_W-1:0]   base_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic [CNT_W-1:0]   run_lo, run_hi, base;
   logic [FP_BITS-1:0] req_fp, fp_bus;
   cell_ctrl_type      ctrl;

   // chain wiring
   logic [FP_BITS-1:0] entry_q [MAX_ENTRIES];
   logic               prior   [MAX_ENTRIES+1];
   logic [MAX_ENTRIES-1:0] at_vec, found_vec;

   logic               found_any, any_at;
   logic [CNT_W-1:0]   slot_enc, slot_val;

   assign accept = start & ~busy_ff;
   assign busy   = busy_ff;

   // clamp run bounds to the store size; unused high fingerprint bits dropped
   always_comb begin
      if (32'(req.run_start) > 32'(MAX_ENTRIES)) begin
         run_lo = MAX_IDX;
      end else begin
         run_lo = CNT_W'(req.run_start);
      end
      if (32'(req.run_end) > 32'(MAX_ENTRIES)) begin
         run_hi = MAX_IDX;
      end else begin
         run_hi = CNT_W'(req.run_end);
      end
      // slot when nothing in the run qualifies; an empty or reversed run uses its start
      base   = (run_lo >= run_hi) ? run_lo : run_hi;
      req_fp = FP_BITS'(req.fingerprint);
   end

   // compare uses the incoming fingerprint, the update cycle uses the held one
   assign fp_bus = busy_ff ? fp_ff : req_fp;

   assign ctrl.capture    = accept;
   assign ctrl.shift_up   = busy_ff && (func_ff == FUNC_INSERT);
   assign ctrl.shift_down = busy_ff && (func_ff == FUNC_REMOVE) && found_any;

   assign prior[0] = 1'b0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic [FP_BITS-1:0] lower, upper;
      if (i == 0) begin : g_first
         assign lower = '0;
      end else begin : g_mid_lo
         assign lower = entry_q[i-1];
      end
      // zero shifts into the top cell on a remove
      if (i == MAX_ENTRIES - 1) begin : g_last
         assign upper = '0;
      end else begin : g_mid_hi
         assign upper = entry_q[i+1];
      end

      spfs_cell #(
         .CELL_IDX (i),
         .FP_BITS  (FP_BITS),
         .CNT_W    (CNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .fp          (fp_bus),
         .run_lo      (run_lo),
         .run_hi      (run_hi),
         .base        (base),
         .prior_in    (prior[i]),
         .prior_out   (prior[i+1]),
         .lower_entry (lower),
         .upper_entry (upper),
         .entry       (entry_q[i]),
         .at_slot     (at_vec[i]),
         .found       (found_vec[i])
      );
   end

   // one-hot slot marker to an index
   always_comb begin
      slot_enc = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (at_vec[i]) begin
            slot_enc = slot_enc | CNT_W'(i);
         end
      end
   end

   assign found_any = |found_vec;
   assign any_at    = |at_vec;
   // no marked cell means the slot lies at the top of the store
   assign slot_val  = any_at ? slot_enc : base_ff;

   // occupancy saturates at both ends
   always_comb begin
      count_in = count_ff;
      if (ctrl.shift_up || (busy_ff && (func_ff == FUNC_INSERT))) begin
         if (count_ff < MAX_IDX) begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (ctrl.shift_down) begin
         if (count_ff != '0) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_in.found     = found_any;
      rsp_in.slot      = IDX_FIELD_W'(slot_val);
      rsp_in.occupancy = IDX_FIELD_W'(count_in);
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (busy_ff) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= busy_ff;
      end
   end

   // transfer payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req.func;
         fp_ff   <= req_fp;
         base_ff <= base;
      end
      if (busy_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[sim/tb.sv]
// self-checking testbench for sorted_packed_fingerprint_store_unit
// drives lookup, insert and remove transfers and checks every result against a predictor
// depends on spfs_pkg and the rtl of the unit
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import spfs_pkg::*;

   localparam int DEPTH         = MAX_ENTRIES_DEFAULT;
   localparam int FPW           = FP_BITS_DEFAULT;
   localparam int unsigned FP_MASK = (1 << FPW) - 1;
   localparam int STALL_LIMIT   = 2000;
   localparam int MAX_REPORTS   = 10;
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;   // undefined code, acts as a lookup

   // fingerprints that repeat often, so lookups and removes actually hit
   localparam logic [7:0] COMMON_FP [8] = '{8'h00, 8'h01, 8'h3C, 8'h7F,
                                            8'h80, 8'hC3, 8'hFE, 8'hFF};

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req   = '0;
   logic    rsp_valid;
   rsp_type rsp;

   // predictor state: a private copy of the table and its occupancy count
   logic [FPW-1:0] fp_table [DEPTH];
   int unsigned    fp_count;

   req_type pending_q [$];      // transfers waiting to be offered
   rsp_type expected_q [$];     // predicted results, oldest first
   int      sender_idle_pct = 0;
   int      mismatch_count  = 0;
   int      stall_cycles    = 0;

   sorted_packed_fingerprint_store_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // search the run, then apply the operation to the private table
   function automatic rsp_type apply_table_op(req_type item);
      int unsigned lo;
      int unsigned hi;
      int unsigned fp;
      int unsigned slot_idx;
      bit          hit;
      bit          located;
      rsp_type     res;
      lo = (item.run_start > DEPTH) ? DEPTH : item.run_start;
      hi = (item.run_end > DEPTH) ? DEPTH : item.run_end;
      fp = item.fingerprint & FP_MASK;
      hit = 1'b0;
      located = 1'b0;
      // empty or reversed run: the slot is the clamped start
      if (lo >= hi) begin
         slot_idx = lo;
      end else begin
         slot_idx = hi;
         for (int i = lo; i < hi && !located; i++) begin
            if (fp <= fp_table[i]) begin
               slot_idx = i;
               hit = (fp == fp_table[i]);
               located = 1'b1;
            end
         end
      end
      case (item.func)
         FUNC_INSERT: begin
            // a slot past the end discards the fingerprint, but the count still moves
            if (slot_idx < DEPTH) begin
               for (int i = DEPTH - 1; i > slot_idx; i--) fp_table[i] = fp_table[i-1];
               fp_table[slot_idx] = fp[FPW-1:0];
            end
            if (fp_count < DEPTH) fp_count++;
         end
         FUNC_REMOVE: begin
            if (hit && slot_idx < DEPTH) begin
               for (int i = slot_idx; i + 1 < DEPTH; i++) fp_table[i] = fp_table[i+1];
               fp_table[DEPTH-1] = '0;
               if (fp_count > 0) fp_count--;
            end
         end
         default: ;   // lookup and the spare code leave the table alone
      endcase
      res.found     = hit;
      res.slot      = 6'(slot_idx);
      res.occupancy = 6'(fp_count);
      return res;
   endfunction

   task automatic queue_request(logic [FUNC_W-1:0] func, int run_lo, int run_hi, int fp);
      req_type item;
      item.func        = func;
      item.run_start   = 6'(run_lo);
      item.run_end     = 6'(run_hi);
      item.fingerprint = 8'(fp);
      pending_q.push_back(item);
   endtask

   // mostly well-formed runs inside the table, with some reversed runs and raw noise
   function automatic req_type make_random_request(bit insert_heavy);
      req_type     item;
      logic [31:0] raw;
      int          pick;
      int          lo;
      raw = $urandom;
      item = raw[$bits(req_type)-1:0];
      pick = $urandom_range(99);
      if (pick < 8) return item;
      lo = $urandom_range(DEPTH);
      item.run_start = 6'(lo);
      if (pick < 14) item.run_start = 6'($urandom_range(63, lo));
      item.run_end = 6'($urandom_range(lo, DEPTH));
      pick = $urandom_range(99);
      if (pick < 3)
         item.func = FUNC_SPARE;
      else if (pick < 28)
         item.func = FUNC_LOOKUP;
      else if (pick < (insert_heavy ? 83 : 48))
         item.func = FUNC_INSERT;
      else
         item.func = FUNC_REMOVE;
      if ($urandom_range(1)) item.fingerprint = COMMON_FP[$urandom_range(7)];
      return item;
   endfunction

   // fill one phase and hold until every transfer of it is taken and answered
   task automatic run_phase(int idle_pct, int count);
      req_type item;
      sender_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) begin
         item = make_random_request(((i / 60) % 2) == 0);
         pending_q.push_back(item);
      end
      while (pending_q.size() != 0 || start || expected_q.size() != 0) @(negedge clock);
   endtask

   // driver: a transfer is taken at an edge where start is high and busy is low
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (start) begin
            expected_q.push_back(apply_table_op(req));
         end
         // one assignment to start per edge, so back-to-back transfers keep it high
         if (pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            start <= 1'b1;
            req   <= pending_q.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: results cannot be held off, so each strobe is taken as it comes
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected result: found %0d slot %0d occupancy %0d",
                           rsp.found, rsp.slot, rsp.occupancy);
            end else begin
               want = expected_q.pop_front();
               if (rsp.found !== want.found || rsp.slot !== want.slot ||
                   rsp.occupancy !== want.occupancy) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("result mismatch: found %0d/%0d slot %0d/%0d occupancy %0d/%0d",
                              want.found, rsp.found, want.slot, rsp.slot,
                              want.occupancy, rsp.occupancy);
               end
            end
         end
         // watchdog on cycles where no transfer moves in either direction
         if (rsp_valid || (start && !busy))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      foreach (fp_table[i]) fp_table[i] = '0;
      fp_count = 0;

      // directed part on the freshly cleared table
      queue_request(FUNC_REMOVE, 0, 32, 8'h00);    // found remove while the count is zero
      queue_request(FUNC_LOOKUP, 0, 32, 8'h00);
      queue_request(FUNC_SPARE, 0, 32, 8'h80);     // spare code behaves as lookup
      queue_request(FUNC_INSERT, 0, 32, 8'hFF);    // slot lands past the top, value dropped
      queue_request(FUNC_INSERT, 0, 0, 8'h00);     // empty run
      queue_request(FUNC_INSERT, 0, 4, 8'h55);
      queue_request(FUNC_INSERT, 0, 4, 8'h55);     // duplicate goes before its twin
      queue_request(FUNC_LOOKUP, 0, 4, 8'h55);
      queue_request(FUNC_REMOVE, 0, 4, 8'h55);
      queue_request(FUNC_INSERT, 63, 40, 8'hAA);   // both bounds clamp to the top
      queue_request(FUNC_LOOKUP, 20, 5, 8'h10);    // reversed run
      queue_request(FUNC_INSERT, 0, 63, 8'h01);    // end clamps
      queue_request(FUNC_REMOVE, 0, 32, 8'hAA);    // missing remove
      queue_request(FUNC_LOOKUP, 31, 32, 8'hFF);
      queue_request(FUNC_INSERT, 31, 32, 8'hFF);
      queue_request(FUNC_REMOVE, 0, 32, 8'hFF);
      queue_request(FUNC_INSERT, 10, 20, 8'hC3);
      queue_request(FUNC_REMOVE, 63, 63, 8'hC3);
      queue_request(FUNC_LOOKUP, 0, 32, 8'hC3);
      for (int i = 0; i < 6; i++) queue_request(FUNC_INSERT, 0, 32, 8'h20 * i);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // phases: back to back, sparse sender, and a moderately gappy sender
      run_phase(0, 175);
      run_phase(83, 175);
      run_phase(0, 175);
      run_phase(35, 175);

      // let any stray strobe show up before judging
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/spfs_pkg.sv
rtl/core/spfs_cell.sv
rtl/core/sorted_packed_fingerprint_store_unit.sv
sim/tb.sv
